// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  // One 32-bit message word on its way from the front end to the core
  typedef struct packed {
    word_t word;
    logic  blk_end;
    logic  msg_end;
  } q_entry_t;

  localparam int QW = $bits(q_entry_t);

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== design/sha256_fifo.sv =====
// ----------------------------------------------------------------------------
// sha256_fifo
// Short first-in first-out queue between the front end and the core.
// ----------------------------------------------------------------------------
module sha256_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/sha256_front.sv =====
// ----------------------------------------------------------------------------
// sha256_front
// Packs message bytes into 32-bit words, counts bits and generates padding.
// ----------------------------------------------------------------------------
module sha256_front
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic [7:0] s_tdata,
  input  logic     s_tuser,
  input  logic     s_tlast,
  output logic     push,
  output q_entry_t entry,
  input  logic     q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MARK = 2'd1;
  localparam logic [1:0] F_FILL = 2'd2;
  localparam logic [1:0] F_LEN  = 2'd3;

  logic [1:0]  state;
  word_t       acc;
  logic [1:0]  bpos;
  logic [3:0]  wcnt;
  logic [63:0] bitcnt;
  logic        accept;
  word_t       acc_upd;
  word_t       mark_word;

  assign s_tready = (state == F_IDLE) && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign acc_upd  = {acc[23:0], s_tdata};

  always_comb begin
    case (bpos)
      2'd0:    mark_word = 32'h80000000;
      2'd1:    mark_word = {acc[7:0], 24'h800000};
      2'd2:    mark_word = {acc[15:0], 16'h8000};
      default: mark_word = {acc[23:0], 8'h80};
    endcase
  end

  always_comb begin
    entry.word    = acc_upd;
    entry.blk_end = (wcnt == 4'd15);
    entry.msg_end = 1'b0;
    push          = 1'b0;
    case (state)
      F_IDLE: begin
        push = accept && s_tuser && (bpos == 2'd3);
      end
      F_MARK: begin
        push       = !q_full;
        entry.word = mark_word;
      end
      F_FILL: begin
        push       = !q_full;
        entry.word = (wcnt == 4'd14) ? bitcnt[63:32] : '0;
      end
      default: begin
        push          = !q_full;
        entry.word    = bitcnt[31:0];
        entry.blk_end = 1'b1;
        entry.msg_end = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser) begin
      acc <= acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      bpos   <= '0;
      wcnt   <= '0;
      bitcnt <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              bpos   <= bpos + 1'b1;
              bitcnt <= bitcnt + 64'd8;
              if (bpos == 2'd3) begin
                wcnt <= wcnt + 1'b1;
              end
            end
            if (s_tlast) begin
              state <= F_MARK;
            end
          end
        end
        F_MARK: begin
          if (push) begin
            wcnt  <= wcnt + 1'b1;
            bpos  <= '0;
            state <= F_FILL;
          end
        end
        F_FILL: begin
          if (push) begin
            wcnt <= wcnt + 1'b1;
            if (wcnt == 4'd14) begin
              state <= F_LEN;
            end
          end
        end
        default: begin
          if (push) begin
            wcnt   <= '0;
            bitcnt <= '0;
            state  <= F_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== design/sha256_core.sv =====
// ----------------------------------------------------------------------------
// sha256_core
// Loads 16 words per block, runs 64 rounds, folds into the chaining words
// and presents the digest as four 64-bit words.
// ----------------------------------------------------------------------------
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  q_entry_t    q_data,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic        m_tlast
);

  localparam logic [1:0] C_LOAD  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_ADD   = 2'd2;
  localparam logic [1:0] C_EMIT  = 2'd3;

  logic [1:0] state;
  logic [5:0] rcnt;
  logic [1:0] oidx;
  logic       last;
  word_t      h [8];
  word_t      v [8];
  word_t      w [16];
  word_t      t1;
  word_t      t2;
  word_t      new_w;
  logic       out_take;

  assign pop      = (state == C_LOAD) && !q_empty;
  assign m_tvalid = (state == C_EMIT);
  assign m_tlast  = (oidx == 2'd3);
  assign m_tdata  = {6'b0, oidx, h[{oidx, 1'b0}], h[{oidx, 1'b1}]};
  assign out_take = m_tvalid && m_tready;

  always_comb begin
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[rcnt] + w[0];
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    new_w = sml_sig1(w[14]) + w[9] + sml_sig0(w[1]) + w[0];
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= q_data.word;
    end else if (state == C_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= new_w;
    end
    if (pop && q_data.blk_end) begin
      v <= h;
    end else if (state == C_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_LOAD;
      rcnt  <= '0;
      oidx  <= '0;
      last  <= 1'b0;
      h     <= IV;
    end else begin
      case (state)
        C_LOAD: begin
          if (pop && q_data.blk_end) begin
            last  <= q_data.msg_end;
            rcnt  <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          rcnt <= rcnt + 1'b1;
          if (rcnt == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          oidx  <= '0;
          state <= last ? C_EMIT : C_LOAD;
        end
        default: begin
          if (out_take) begin
            oidx <= oidx + 1'b1;
            if (m_tlast) begin
              h     <= IV;
              state <= C_LOAD;
            end
          end
        end
      endcase
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == C_ROUND || state == C_EMIT) |-> !pop)
    else $error("queue popped while core busy");

  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (out_take && m_tlast) |=> (h[0] == IV[0] && h[7] == IV[7]))
    else $error("chaining words not reinitialized after digest");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (out_take && !m_tlast) |=> (m_tvalid && oidx == $past(oidx) + 2'd1))
    else $error("digest word index did not advance");

  a_rounds_after_block: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.blk_end) |=> (state == C_ROUND && rcnt == 6'd0))
    else $error("rounds did not start after a full block");

endmodule

// ===== design/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 hasher taking one message byte per request and returning the
// 256-bit digest as four 64-bit big-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one request carries one byte in s_tdata. s_tuser marks
//   the byte as present; a request with s_tuser low carries no byte. s_tlast
//   ends the message after this request's byte and starts padding.
//   Output channel m_*: four requests per message, digest word 0 (most
//   significant) first; m_tlast marks word 3.
//   Throughput: bytes enter at one per cycle, outside padding, until the word
//   queue fills. The core spends 64 rounds and one fold per 64-byte block,
//   and during them the front end can only bank four words; the remaining
//   48 bytes of the next block then enter at one per cycle while the core
//   loads.
//   Digest: padding fills out the last block, adding one when the length
//   does not fit; after popping the final block's last word the core runs
//   the rounds and the fold, then presents the first digest word.
//   Reset: rst (synchronous, high) restores the initial hash values and
//   clears all counters and the queue.
//   Stall: while the receiver holds m_tready low the core holds the digest;
//   the front end keeps taking bytes of the next message until the queue is
//   full, then drops s_tready.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top
  import sha256_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] digest_word, [65:64] word_index
  output logic        m_tlast    // last_word
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t wr_entry;
  q_entry_t rd_entry;

  // front end: pack bytes into words and append padding
  sha256_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser[0]),
    .s_tlast  (s_tlast),
    .push     (push),
    .entry    (wr_entry),
    .q_full   (q_full)
  );

  // decouple byte intake from compression
  sha256_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wr_entry),
    .full  (q_full),
    .pop   (pop),
    .rdata (rd_entry),
    .empty (q_empty)
  );

  // back end: compression rounds and digest output
  sha256_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (rd_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
